// File: rtl/top_k_hash_min_heap_defines.svh
// Assertion macros for the top-k hash store.
// Included by files that carry concurrent checks; needs clk and rst in scope.
`ifndef TOP_K_HASH_MIN_HEAP_DEFINES_SVH
`define TOP_K_HASH_MIN_HEAP_DEFINES_SVH

`ifndef SYNTHESIS
// cond must hold at every edge outside reset
`define TKH_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tkh check failed");
// cons must hold in the cycle after ante
`define TKH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tkh sequence check failed");
`else
`define TKH_ASSERT(lbl, cond)
`define TKH_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/tkh_pkg.sv
// Shared constants and types for the top-k hash store.
// No dependencies.
package tkh_pkg;

  localparam int HEAP_SIZE_DEF  = 32;
  localparam int HASH_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;  // width of hash in and value out

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  // result of one child compare step
  typedef struct packed {
    logic sel_right;  // right child is the smaller one
    logic move;       // smaller child is below the key, swap down
  } cmp_res_t;

endpackage

// File: rtl/tkh_ram.sv
// Generic simple RAM: one write port, two registered read ports.
// No dependencies.
module tkh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     ra_en,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic [WIDTH-1:0]         ra_data,
  input  logic                     rb_en,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ra_en) begin
      ra_data <= mem[ra_addr];
    end
    if (rb_en) begin
      rb_data <= mem[rb_addr];
    end
  end

endmodule

// File: rtl/tkh_cmp.sv
// Shared compare unit of the sift-down walk: picks the smaller child and
// decides whether it moves up past the key. Depends on tkh_pkg.
module tkh_cmp #(
  parameter int HW = tkh_pkg::HASH_WIDTH_DEF
) (
  input  logic [HW-1:0]        left,
  input  logic [HW-1:0]        right,
  input  logic                 right_ok,  // right child lies inside the heap
  input  logic [HW-1:0]        key,
  output logic [HW-1:0]        child,
  output tkh_pkg::cmp_res_t    res
);
  import tkh_pkg::*;

  logic sel_r;

  // equal children: left wins
  assign sel_r         = right_ok && (right < left);
  assign child         = sel_r ? right : left;
  assign res.sel_right = sel_r;
  assign res.move      = child < key;

endmodule

// File: rtl/top_k_hash_min_heap.sv
// Top level of the top-k hash store: sequencer, heap RAM, output register.
// Depends on tkh_pkg, tkh_ram, tkh_cmp and top_k_hash_min_heap_defines.svh.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-------------------------------------
//  s_*     | in  | s_tvalid/tready  | tdata = hash, tuser = cmd
//  m_*     | out | m_tvalid/tready  | tdata = value, tlast = is_last
//
// Insert: the root is compared first and a hash that does not beat it ends there;
// otherwise the key moves down a level per read and compare of the children until it
// settles at a leaf or stops above one. Drain: HEAP_SIZE-1 extract steps, each a read
// and a tail swap plus a sift-down, then a read and an output load per result.
// Reset is synchronous; per-entry valid flags make the store read as zeros at once.
// s_tready is high only while idle; an m_* stall holds the drain, nothing is lost.
`include "top_k_hash_min_heap_defines.svh"

module top_k_hash_min_heap #(
  parameter int HEAP_SIZE  = tkh_pkg::HEAP_SIZE_DEF,
  parameter int HASH_WIDTH = tkh_pkg::HASH_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [tkh_pkg::VALUE_W-1:0] s_tdata,   // [31:0] hash
  input  logic [0:0]                  s_tuser,   // [0] cmd
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [tkh_pkg::VALUE_W-1:0] m_tdata,   // [31:0] value
  output logic                        m_tlast    // is_last
);
  import tkh_pkg::*;

  localparam int AW = $clog2(HEAP_SIZE);
  localparam int NW = $clog2(HEAP_SIZE + 1);
  localparam int CW = AW + 2;  // wide enough for child indexes and counts
  localparam int HW = HASH_WIDTH;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_INS_CMP  = 3'd1;
  localparam logic [2:0] ST_SIFT_RD  = 3'd2;
  localparam logic [2:0] ST_SIFT_CMP = 3'd3;
  localparam logic [2:0] ST_DR_RD    = 3'd4;
  localparam logic [2:0] ST_DR_SWP   = 3'd5;
  localparam logic [2:0] ST_OUT_RD   = 3'd6;
  localparam logic [2:0] ST_OUT_WAIT = 3'd7;

  logic [2:0]          state, state_next;
  logic                drain, drain_next;      // sift-down belongs to a drain
  logic [NW-1:0]       cnt, cnt_next;          // live heap size during a walk
  logic [AW-1:0]       idx, idx_next;          // hole position of the walk
  logic [NW-1:0]       out_idx, out_idx_next;  // next entry to emit
  logic [HW-1:0]       key, key_next;          // value being sifted down
  logic [HEAP_SIZE-1:0] vld, vld_next;         // entry written since clear

  // RAM ports
  logic          we;
  logic [AW-1:0] waddr;
  logic [HW-1:0] wdata;
  logic          ra_en, rb_en;
  logic [AW-1:0] ra_addr, rb_addr;
  logic [HW-1:0] ra_raw, rb_raw;
  logic          ra_vld, rb_vld;
  logic [HW-1:0] rd_a, rd_b;

  // compare unit
  logic [HW-1:0] child;
  cmp_res_t      cres;
  logic          right_ok;

  // child indexes
  logic [CW-1:0] lidx, ridx, ridx_q;
  logic          leaf;

  // width adaption between the 32-bit fields and the stored hash
  logic [HW+VALUE_W-1:0] hash_ext, val_ext;

  logic accept, load;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign hash_ext = {{HW{1'b0}}, s_tdata};
  assign val_ext  = {{VALUE_W{1'b0}}, rd_a};

  assign lidx = {1'b0, idx, 1'b1};
  assign ridx = lidx + CW'(1);
  assign leaf = lidx >= CW'(cnt);

  // a never-written entry reads as empty
  assign rd_a = ra_vld ? ra_raw : '0;
  assign rd_b = rb_vld ? rb_raw : '0;

  assign load = (state == ST_OUT_WAIT) && (!m_tvalid || m_tready);

  tkh_ram #(
    .WIDTH (HW),
    .DEPTH (HEAP_SIZE)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .ra_en   (ra_en),
    .ra_addr (ra_addr),
    .ra_data (ra_raw),
    .rb_en   (rb_en),
    .rb_addr (rb_addr),
    .rb_data (rb_raw)
  );

  tkh_cmp #(
    .HW (HW)
  ) u_cmp (
    .left     (rd_a),
    .right    (rd_b),
    .right_ok (right_ok),
    .key      (key),
    .child    (child),
    .res      (cres)
  );

  // right child existence, captured with the reads
  always_ff @(posedge clk) begin
    if (rb_en) begin
      ridx_q <= ridx;
    end
  end
  assign right_ok = ridx_q < CW'(cnt);

  always_ff @(posedge clk) begin
    if (ra_en) begin
      ra_vld <= vld[ra_addr];
    end
    if (rb_en) begin
      rb_vld <= vld[rb_addr];
    end
  end

  always_comb begin
    state_next   = state;
    drain_next   = drain;
    cnt_next     = cnt;
    idx_next     = idx;
    out_idx_next = out_idx;
    key_next     = key;
    vld_next     = vld;
    we           = 1'b0;
    waddr        = idx;
    wdata        = key;
    ra_en        = 1'b0;
    rb_en        = 1'b0;
    ra_addr      = '0;
    rb_addr      = '0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cnt_next = NW'(HEAP_SIZE);
          idx_next = '0;
          if (s_tuser[0] == CMD_DRAIN) begin
            drain_next = 1'b1;
            state_next = ST_DR_RD;
          end else begin
            drain_next = 1'b0;
            key_next   = hash_ext[HW-1:0];
            ra_en      = 1'b1;           // fetch root
            state_next = ST_INS_CMP;
          end
        end
      end
      ST_INS_CMP: begin
        // only a strictly larger hash displaces the minimum
        state_next = (key > rd_a) ? ST_SIFT_RD : ST_IDLE;
      end
      ST_SIFT_RD: begin
        if (leaf) begin
          we = 1'b1;                     // key settles in the hole
          if (!drain) begin
            state_next = ST_IDLE;
          end else if (cnt > NW'(1)) begin
            state_next = ST_DR_RD;
          end else begin
            out_idx_next = '0;
            state_next   = ST_OUT_RD;
          end
        end else begin
          ra_en      = 1'b1;
          rb_en      = 1'b1;
          ra_addr    = lidx[AW-1:0];
          rb_addr    = ridx[AW-1:0];
          state_next = ST_SIFT_CMP;
        end
      end
      ST_SIFT_CMP: begin
        we = 1'b1;
        if (cres.move) begin
          // smaller child moves up into the hole
          wdata      = child;
          idx_next   = cres.sel_right ? ridx_q[AW-1:0] : ridx_q[AW-1:0] - AW'(1);
          state_next = ST_SIFT_RD;
        end else begin
          if (!drain) begin
            state_next = ST_IDLE;
          end else if (cnt > NW'(1)) begin
            state_next = ST_DR_RD;
          end else begin
            out_idx_next = '0;
            state_next   = ST_OUT_RD;
          end
        end
      end
      ST_DR_RD: begin
        ra_en      = 1'b1;
        rb_en      = 1'b1;
        ra_addr    = '0;
        rb_addr    = AW'(cnt - NW'(1));
        state_next = ST_DR_SWP;
      end
      ST_DR_SWP: begin
        // minimum goes to the tail, tail entry sifts down from the root
        we         = 1'b1;
        waddr      = AW'(cnt - NW'(1));
        wdata      = rd_a;
        key_next   = rd_b;
        cnt_next   = cnt - NW'(1);
        idx_next   = '0;
        state_next = ST_SIFT_RD;
      end
      ST_OUT_RD: begin
        ra_en      = 1'b1;
        ra_addr    = out_idx[AW-1:0];
        state_next = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (load) begin
          out_idx_next = out_idx + NW'(1);
          if (out_idx == NW'(HEAP_SIZE - 1)) begin
            vld_next   = '0;             // store empties after the drain
            state_next = ST_IDLE;
          end else begin
            state_next = ST_OUT_RD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (we) begin
      vld_next[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      drain   <= 1'b0;
      cnt     <= '0;
      idx     <= '0;
      out_idx <= '0;
      vld     <= '0;
    end else begin
      state   <= state_next;
      drain   <= drain_next;
      cnt     <= cnt_next;
      idx     <= idx_next;
      out_idx <= out_idx_next;
      vld     <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= val_ext[VALUE_W-1:0];
      m_tlast <= (out_idx == NW'(HEAP_SIZE - 1));
    end
  end

  // checks
  `TKH_ASSERT(a_no_rw_clash, !(we && ra_en && (ra_addr == waddr)))
  `TKH_ASSERT(a_waddr_in_heap, !we || (32'(waddr) < HEAP_SIZE))
  `TKH_ASSERT_NEXT(a_accept_leaves_idle, s_tvalid && s_tready, state != ST_IDLE)

endmodule

// File: tb/tb_top_k_hash_min_heap.sv
// Testbench for top_k_hash_min_heap: streams insert and drain transactions and
// checks every drained entry against a behavioral top-k store kept in the bench.
// Depends on tkh_pkg and the top_k_hash_min_heap RTL.
`timescale 1ns / 100ps

module tb_top_k_hash_min_heap;
  import tkh_pkg::*;

  localparam int HEAP_SIZE   = HEAP_SIZE_DEF;
  localparam int HASH_WIDTH  = HASH_WIDTH_DEF;
  localparam int STALL_LIMIT = 5000;  // cycles with no transaction on either side
  localparam int TAIL_CYCLES = 40;    // quiet time after the last drained entry
  localparam int RANDOM_ITEMS = 450;

  typedef struct {
    logic               cmd;
    logic [VALUE_W-1:0] hash;
  } heap_cmd_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               is_last;
  } drain_entry_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [VALUE_W-1:0] s_tdata = '0;   // [31:0] hash
  logic [0:0]         s_tuser = '0;   // [0] cmd
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [VALUE_W-1:0] m_tdata;        // [31:0] value
  logic               m_tlast;

  heap_cmd_t          pending_cmds[$];
  drain_entry_t       drain_entries_due[$];
  logic [VALUE_W-1:0] topk_store[HEAP_SIZE];
  heap_cmd_t          cur_cmd;
  int                 errors = 0;
  int                 s_gap = 0;
  int                 m_gap = 0;
  int                 stall_cycles = 0;
  bit                 s_took = 1'b0;
  bit                 quiet = 1'b0;   // no more idling on either side

  top_k_hash_min_heap #(
    .HEAP_SIZE (HEAP_SIZE),
    .HASH_WIDTH(HASH_WIDTH)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Top-k prediction. The store only matters as a multiset: an insert
  // replaces the current minimum (the heap root) when strictly greater, so
  // zero and anything tied with the root never get in. A drain gives the
  // whole store largest first, zero slots too, and empties it.
  function automatic void predict_topk(heap_cmd_t c);
    logic [VALUE_W-1:0] h;
    logic [VALUE_W-1:0] sorted[$];
    int                 min_idx;
    drain_entry_t       e;
    h = c.hash & VALUE_W'((64'd1 << HASH_WIDTH) - 64'd1);
    min_idx = 0;
    if (c.cmd == CMD_INSERT) begin
      for (int i = 1; i < HEAP_SIZE; i++)
        if (topk_store[i] < topk_store[min_idx]) min_idx = i;
      if (h > topk_store[min_idx]) topk_store[min_idx] = h;
    end else begin
      for (int i = 0; i < HEAP_SIZE; i++) sorted.push_back(topk_store[i]);
      sorted.rsort();
      for (int i = 0; i < HEAP_SIZE; i++) begin
        e.value   = sorted[i];
        e.is_last = (i == HEAP_SIZE - 1);
        drain_entries_due.push_back(e);
        topk_store[i] = '0;
      end
    end
  endfunction

  function automatic void queue_cmd(logic cmd, logic [VALUE_W-1:0] hash);
    heap_cmd_t c;
    c.cmd  = cmd;
    c.hash = hash;
    pending_cmds.push_back(c);
  endfunction

  // Hash mix: full-range values for bit coverage, tiny values for ties and
  // zeros, the extremes, and large values that crowd the top of the range.
  function automatic logic [VALUE_W-1:0] pick_hash();
    logic [VALUE_W-1:0] h;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: h = $urandom;
      4, 5:       h = $urandom_range(0, 15);
      6: begin
        case ($urandom_range(0, 4))
          0:       h = '0;
          1:       h = 32'd1;
          2:       h = 32'h8000_0000;
          3:       h = 32'hFFFF_FFFE;
          default: h = 32'hFFFF_FFFF;
        endcase
      end
      default:    h = {8'hFF, 24'($urandom_range(0, 255))};
    endcase
    return h;
  endfunction

  // Stimulus: directed corner cases, then well-formed fill-and-drain runs.
  initial begin
    int n_items;
    int run_len;
    for (int i = 0; i < HEAP_SIZE; i++) topk_store[i] = '0;

    queue_cmd(CMD_DRAIN, '0);              // drain of an empty store: all zeros
    queue_cmd(CMD_INSERT, '0);             // zero never enters
    queue_cmd(CMD_INSERT, 32'hFFFF_FFFF);
    queue_cmd(CMD_INSERT, 32'd1);
    queue_cmd(CMD_INSERT, 32'd1);          // duplicate
    queue_cmd(CMD_INSERT, 32'h8000_0000);
    queue_cmd(CMD_INSERT, 32'hFFFF_FFFF);  // duplicate of the maximum
    queue_cmd(CMD_INSERT, 32'h5555_5555);
    queue_cmd(CMD_INSERT, 32'hAAAA_AAAA);
    queue_cmd(CMD_DRAIN, 32'hFFFF_FFFF);   // hash field ignored on drain
    queue_cmd(CMD_INSERT, 32'd7);
    queue_cmd(CMD_DRAIN, 32'h1234_5678);

    // Runs mostly below capacity, some overfilling it so replacement and the
    // equal-to-root rejection get exercised on a full store.
    n_items = 0;
    while (n_items < RANDOM_ITEMS) begin
      run_len = ($urandom_range(0, 2) == 0) ? $urandom_range(HEAP_SIZE + 1, 80)
                                            : $urandom_range(1, HEAP_SIZE);
      repeat (run_len) queue_cmd(CMD_INSERT, pick_hash());
      queue_cmd(CMD_DRAIN, $urandom);
      n_items += run_len + 1;
    end

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() > 60) @(posedge clk);
    quiet = 1'b1;

    while (pending_cmds.size() > 0 || s_tvalid) @(posedge clk);
    while (drain_entries_due.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Driver: next transaction goes out at the falling edge once the previous
  // one was taken; an idle burst may follow any accepted transaction.
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || s_took)) begin
      if (s_gap > 0) begin
        s_tvalid <= 1'b0;
        s_gap = s_gap - 1;
      end else if (pending_cmds.size() > 0) begin
        cur_cmd = pending_cmds.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= cur_cmd.cmd;
        s_tdata  <= cur_cmd.hash;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver backpressure: random stall bursts until the quiet tail.
  always @(negedge clk) begin
    if (!rst) begin
      if (m_gap > 0) begin
        m_tready <= 1'b0;
        m_gap = m_gap - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        m_gap = $urandom_range(0, 6);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Rising edge: record accepted input transactions into the predictor, then
  // check any accepted output transaction against the oldest expectation.
  always @(posedge clk) begin
    drain_entry_t exp_e;
    heap_cmd_t    got_cmd;
    s_took = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        s_took = 1'b1;
        got_cmd.cmd  = s_tuser[0];
        got_cmd.hash = s_tdata;
        predict_topk(got_cmd);
        if (!quiet && $urandom_range(0, 3) == 0) s_gap = $urandom_range(1, 7);
      end
      if (m_tvalid && m_tready) begin
        if (drain_entries_due.size() == 0) begin
          $display("%0t: unexpected result exp none got value %h last %b",
                   $time, m_tdata, m_tlast);
          errors++;
        end else begin
          exp_e = drain_entries_due.pop_front();
          if (m_tdata !== exp_e.value) begin
            $display("%0t: value mismatch exp %h got %h", $time, exp_e.value, m_tdata);
            errors++;
          end
          if (m_tlast !== exp_e.is_last) begin
            $display("%0t: is_last mismatch exp %b got %b", $time, exp_e.is_last, m_tlast);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no transaction means the block hung.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d entries still expected", $time, drain_entries_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
